// ===== hw/rtl/bts_pkg.sv =====
// ---------------------------------------------------------------------------
// Buzzer tone sequencer package
// Shared widths, codes, the boot motif table and the tone helper functions.
// ---------------------------------------------------------------------------
package bts_pkg;

    localparam int FREQ_W   = 16;
    localparam int DUTY_W   = 7;
    localparam int TIME_W   = 32;
    localparam int VOL_W    = 7;
    localparam int LEN_W    = 8;    // note duration and in-note elapsed time
    localparam int MAG_W    = 10;   // largest sweep span of the motif
    localparam int PROD_W   = MAG_W + LEN_W;
    localparam int IDX_W    = 4;
    localparam int NOTE_CNT = 11;

    localparam logic [IDX_W-1:0]  LAST_NOTE = IDX_W'(NOTE_CNT - 1);
    localparam logic [TIME_W-1:0] BEEP_MS   = TIME_W'(80);
    localparam logic [FREQ_W-1:0] BEEP_HZ   = FREQ_W'(2200);

    // volume * 127 / 100 as a multiply by 127 * 5243 / 2^19
    localparam int DUTY_RECIP = 665861;
    localparam int DUTY_SHIFT = 19;
    localparam int DUTY_PW    = VOL_W + 20;

    localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(127);
    localparam logic [VOL_W-1:0]  VOL_RST  = VOL_W'(100);

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_BOOT   = 2'd1,
        OP_NOTIFY = 2'd2,
        OP_STOP   = 2'd3
    } t_op;

    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_VOLUME = 1'b1;

    typedef struct packed {
        logic [FREQ_W-1:0] lo;
        logic [FREQ_W-1:0] hi;
        logic [LEN_W-1:0]  len;
    } t_note;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag;
        logic [LEN_W-1:0] el;
        logic [LEN_W-1:0] len;
    } t_md_req;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
        logic              reconf;
        logic              dutyw;
    } t_tone;

    function automatic t_note note_at(input logic [IDX_W-1:0] idx);
        t_note n;
        case (idx)
            4'd0:    n = '{16'd300,  16'd1200, 8'd160};
            4'd1:    n = '{16'd0,    16'd0,    8'd25};
            4'd2:    n = '{16'd659,  16'd659,  8'd45};
            4'd3:    n = '{16'd0,    16'd0,    8'd12};
            4'd4:    n = '{16'd831,  16'd831,  8'd45};
            4'd5:    n = '{16'd0,    16'd0,    8'd12};
            4'd6:    n = '{16'd988,  16'd988,  8'd45};
            4'd7:    n = '{16'd0,    16'd0,    8'd25};
            4'd8:    n = '{16'd2400, 16'd1600, 8'd60};
            4'd9:    n = '{16'd0,    16'd0,    8'd20};
            4'd10:   n = '{16'd1319, 16'd1319, 8'd100};
            default: n = '{16'd0,    16'd0,    8'd1};
        endcase
        return n;
    endfunction

    function automatic logic [DUTY_W-1:0] duty_of_volume(input logic [VOL_W-1:0] vol);
        logic [DUTY_PW-1:0] p;
        logic [DUTY_PW-DUTY_SHIFT-1:0] d;
        p = DUTY_PW'(vol) * DUTY_PW'(DUTY_RECIP);
        d = p[DUTY_PW-1:DUTY_SHIFT];
        return (d > (DUTY_PW-DUTY_SHIFT)'(DUTY_MAX)) ? DUTY_MAX : d[DUTY_W-1:0];
    endfunction

    // Applies one tone change against the current frequency and duty.
    function automatic t_tone set_tone(input logic [FREQ_W-1:0] f,
                                       input logic [FREQ_W-1:0] cur_f,
                                       input logic [DUTY_W-1:0] cur_d,
                                       input logic [DUTY_W-1:0] vol_duty);
        t_tone t;
        t.freq   = f;
        t.duty   = (f != '0) ? vol_duty : '0;
        t.reconf = (f != '0) && (f != cur_f);
        t.dutyw  = t.reconf || (t.duty != cur_d);
        return t;
    endfunction

endpackage

// ===== hw/rtl/buzzer_tone_sequencer.sv =====
// ---------------------------------------------------------------------------
// Buzzer tone sequencer
// Plays the boot motif with linear sweeps and coalesced notification beeps,
// and reports the timer frequency, PWM duty and write strobes per event.
//
//   Channel  | Direction | Payload
//   ---------+-----------+----------------------------------------------
//   s        | in        | tuser: op; tdata: now_ms
//   m        | out       | tdata: frequency, duty, reconfigure, duty_written
//   cfg      | in        | index 0 enable, index 1 volume
//
// A play, notify or stop event, or a silenced tick, goes from its transfer
// straight to the emit state. Another tick passes the tick state and, while
// the boot motif plays, a walk step per motif note looked at; a tick inside
// a note skips the notify check and waits on the bit-serial multiply/divide.
// Reset is synchronous and active low; the block is ready right after it.
// A result waits in the output register while the next event is accepted.
// ---------------------------------------------------------------------------
module buzzer_tone_sequencer
    import bts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [VOL_W-1:0] i_cfg_wdata,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [31:0]      i_s_tdata,   // [31:0] now_ms
    input  logic [1:0]       i_s_tuser,   // [1:0] op
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [31:0]      o_m_tdata    // [15:0] frequency, [22:16] duty,
                                          // [23] reconfigure, [24] duty_written
);

    typedef enum logic [2:0] {S_IDLE, S_TICK, S_WALK, S_CALC, S_NOTE, S_EMIT} t_fsm;
    typedef enum logic [1:0] {
        SND_NONE = 2'd0, SND_BOOT_PENDING = 2'd1, SND_BOOT = 2'd2, SND_MESSAGE = 2'd3
    } t_snd;

    t_fsm               r_fsm;
    t_snd               r_snd;
    logic               r_en;
    logic [DUTY_W-1:0]  r_vol_duty;
    logic [TIME_W-1:0]  r_start;
    logic               r_pend;
    logic [FREQ_W-1:0]  r_freq;
    logic [DUTY_W-1:0]  r_duty;
    logic               r_reconf;
    logic               r_dutyw;
    logic [TIME_W-1:0]  r_now;
    logic [TIME_W-1:0]  r_el;
    logic [IDX_W-1:0]   r_idx;
    logic [FREQ_W-1:0]  r_lo;
    logic               r_neg;
    logic               r_ovalid;
    logic [31:0]        r_odata;

    logic               w_accept;
    t_op                w_op;
    logic               w_silent;
    t_snd               w_snd_eff;
    logic [TIME_W-1:0]  w_start_eff;
    logic [TIME_W-1:0]  w_el;
    t_note              w_note;
    logic               w_hit;
    logic               w_apply;
    logic [FREQ_W-1:0]  w_f;
    t_tone              w_tone;
    logic               w_md_done;
    logic [MAG_W-1:0]   w_md_quo;
    t_md_req            w_md_req;
    logic [FREQ_W-1:0]  w_sweep;

    assign o_s_tready  = (r_fsm == S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_op        = t_op'(i_s_tuser);
    assign w_silent    = !r_en || (r_vol_duty == '0);

    assign w_snd_eff   = (r_snd == SND_BOOT_PENDING) ? SND_BOOT : r_snd;
    assign w_start_eff = (r_snd == SND_BOOT_PENDING) ? r_now : r_start;
    assign w_el        = r_now - w_start_eff;

    assign w_note = note_at(r_idx);
    assign w_hit  = (r_el[TIME_W-1:LEN_W] == '0) && (r_el[LEN_W-1:0] < w_note.len);

    assign w_md_req.start = (r_fsm == S_WALK) && w_hit;
    assign w_md_req.mag   = (w_note.hi < w_note.lo) ? MAG_W'(w_note.lo - w_note.hi)
                                                    : MAG_W'(w_note.hi - w_note.lo);
    assign w_md_req.el    = r_el[LEN_W-1:0];
    assign w_md_req.len   = w_note.len;

    // The quotient magnitude is truncated, so this is division toward zero.
    assign w_sweep = r_neg ? (r_lo - FREQ_W'(w_md_quo)) : (r_lo + FREQ_W'(w_md_quo));

    bts_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_md_req),
        .o_done  (w_md_done),
        .o_quo   (w_md_quo)
    );

    always_comb begin
        w_apply = 1'b0;
        w_f     = '0;
        case (r_fsm)
            S_IDLE: begin
                if (w_accept && ((w_op == OP_STOP) || ((w_op == OP_TICK) && w_silent))) begin
                    w_apply = 1'b1;
                end
            end
            S_TICK: begin
                if ((w_snd_eff == SND_MESSAGE) && (w_el >= BEEP_MS)) begin
                    w_apply = 1'b1;
                end
            end
            S_WALK: begin
                if (!w_hit && (r_idx == LAST_NOTE)) begin
                    w_apply = 1'b1;
                end
            end
            S_CALC: begin
                if (w_md_done) begin
                    w_apply = 1'b1;
                    w_f     = w_sweep;
                end
            end
            S_NOTE: begin
                if (((r_snd == SND_NONE) && r_pend) || (r_snd == SND_MESSAGE)) begin
                    w_apply = 1'b1;
                    w_f     = BEEP_HZ;
                end
            end
            default: w_apply = 1'b0;
        endcase
    end

    assign w_tone = set_tone(w_f, r_freq, r_duty, r_vol_duty);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm      <= S_IDLE;
            r_snd      <= SND_NONE;
            r_en       <= 1'b1;
            r_vol_duty <= duty_of_volume(VOL_RST);
            r_start    <= '0;
            r_pend     <= 1'b0;
            r_freq     <= '0;
            r_duty     <= '0;
            r_reconf   <= 1'b0;
            r_dutyw    <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE: r_en       <= i_cfg_wdata[0];
                    CFG_VOLUME: r_vol_duty <= duty_of_volume(i_cfg_wdata);
                    default:    r_en       <= r_en;
                endcase
            end

            if (w_apply) begin
                r_freq   <= w_tone.freq;
                r_duty   <= w_tone.duty;
                r_reconf <= r_reconf | w_tone.reconf;
                r_dutyw  <= r_dutyw | w_tone.dutyw;
            end

            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_fsm)
                S_IDLE: begin
                    if (w_accept) begin
                        r_now    <= i_s_tdata;
                        r_reconf <= w_apply && w_tone.reconf;
                        r_dutyw  <= w_apply && w_tone.dutyw;
                        r_fsm    <= S_EMIT;
                        case (w_op)
                            OP_TICK: begin
                                if (w_silent) begin
                                    r_snd  <= SND_NONE;
                                    r_pend <= 1'b0;
                                end else begin
                                    r_fsm <= S_TICK;
                                end
                            end
                            OP_BOOT: begin
                                if (!w_silent) begin
                                    r_snd <= SND_BOOT_PENDING;
                                end
                            end
                            OP_NOTIFY: r_pend <= 1'b1;
                            OP_STOP: begin
                                r_snd  <= SND_NONE;
                                r_pend <= 1'b0;
                            end
                            default: r_fsm <= S_EMIT;
                        endcase
                    end
                end
                S_TICK: begin
                    r_start <= w_start_eff;
                    r_snd   <= w_snd_eff;
                    r_el    <= w_el;
                    r_idx   <= '0;
                    if (w_snd_eff == SND_BOOT) begin
                        r_fsm <= S_WALK;
                    end else begin
                        if ((w_snd_eff == SND_MESSAGE) && (w_el >= BEEP_MS)) begin
                            r_snd <= SND_NONE;
                        end
                        r_fsm <= S_NOTE;
                    end
                end
                S_WALK: begin
                    if (w_hit) begin
                        r_lo  <= w_note.lo;
                        r_neg <= (w_note.hi < w_note.lo);
                        r_fsm <= S_CALC;
                    end else begin
                        r_el <= r_el - TIME_W'(w_note.len);
                        if (r_idx == LAST_NOTE) begin
                            r_snd <= SND_NONE;
                            r_fsm <= S_NOTE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_CALC: begin
                    if (w_md_done) begin
                        r_fsm <= S_EMIT;
                    end
                end
                S_NOTE: begin
                    if ((r_snd == SND_NONE) && r_pend) begin
                        r_pend  <= 1'b0;
                        r_start <= r_now;
                        r_snd   <= SND_MESSAGE;
                    end
                    r_fsm <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {7'd0, r_dutyw, r_reconf, r_duty, r_freq};
                        r_fsm    <= S_IDLE;
                    end
                end
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

endmodule

// ===== hw/rtl/bts_muldiv.sv =====
// ---------------------------------------------------------------------------
// Bit-serial sweep interpolator
// Computes mag * el / len with one shift-add step per cycle for the product
// and one restoring division step per cycle for the quotient.
// ---------------------------------------------------------------------------
module bts_muldiv
    import bts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_md_req          i_req,
    output logic             o_done,
    output logic [MAG_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(LEN_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} t_mstate;

    t_mstate            r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic [PROD_W-1:0]  r_mcand;
    logic [LEN_W-1:0]   r_mplier;
    logic [PROD_W-1:0]  r_acc;
    logic [LEN_W-1:0]   r_rem;
    logic [LEN_W-1:0]   r_len;

    logic [LEN_W:0]     w_trial;
    logic               w_ge;
    logic [LEN_W:0]     w_diff;

    assign w_trial = {r_rem, r_acc[PROD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_len});
    assign w_diff  = w_trial - {1'b0, r_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_mcand  <= PROD_W'(i_req.mag);
                        r_mplier <= i_req.el;
                        r_len    <= i_req.len;
                        r_acc    <= '0;
                        r_cnt    <= '0;
                        r_state  <= M_MUL;
                    end
                end
                M_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[LEN_W-1:1]};
                    r_cnt    <= r_cnt + 1'b1;
                    if (r_cnt == MUL_LAST) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_state <= M_DIV;
                    end
                end
                M_DIV: begin
                    // The quotient bits shift into the dividend register.
                    r_rem <= w_ge ? w_diff[LEN_W-1:0] : w_trial[LEN_W-1:0];
                    r_acc <= {r_acc[PROD_W-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_done  <= 1'b1;
                        r_state <= M_IDLE;
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_acc[MAG_W-1:0];

endmodule

// ===== hw/rtl/bts_checker.sv =====
// ---------------------------------------------------------------------------
// Buzzer tone sequencer port checker
// Watches the result channel of the top level for consistent tone reports.
// ---------------------------------------------------------------------------
module bts_checker
    import bts_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    logic [FREQ_W-1:0] w_freq;
    logic [DUTY_W-1:0] w_duty;
    logic              w_reconf;
    logic              w_dutyw;

    assign w_freq   = o_m_tdata[15:0];
    assign w_duty   = o_m_tdata[22:16];
    assign w_reconf = o_m_tdata[23];
    assign w_dutyw  = o_m_tdata[24];

    // A stalled result must hold until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Silence always reports zero duty.
    a_silent_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (w_freq == '0) |-> (w_duty == '0))
        else $error("nonzero duty while silent");

    // A timer reconfiguration always comes with a duty write.
    a_reconf_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_reconf |-> w_dutyw)
        else $error("reconfigure without duty write");

    // The timer is never reconfigured to silence.
    a_reconf_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_reconf |-> (w_freq != '0))
        else $error("reconfigure to zero frequency");

endmodule

bind buzzer_tone_sequencer bts_checker u_bts_checker (.*);
